@@ design/sfpwe_pkg.sv @@
// Shared types and constants for the serial frame pulse-width encoder.
`default_nettype none
package sfpwe_pkg;

   localparam int FRAME_MAX_BITS   = 12;
   localparam int PULSE_MAX_BITS   = 8;
   localparam int BIT_TICKS_DEFAULT = 16;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] PULSE_ONE_TICKS_M1  = 8'd23;
   localparam logic [7:0] PULSE_ZERO_TICKS_M1 = 8'd15;

   typedef enum logic [1:0] {
      MODE_8N1    = 2'd0,
      MODE_8E2    = 2'd1,
      MODE_PULSE  = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [3:0] pulse_bit_count;
   } req_type;

   typedef struct packed {
      logic [7:0] run_ticks;
      logic       last_run;
   } rsp_type;

   // One classified byte: line levels and a mark on the last bit of every run.
   typedef struct packed {
      logic                      pulse;
      logic [FRAME_MAX_BITS-1:0] levels;
      logic [FRAME_MAX_BITS-1:0] run_ends;
   } job_type;

endpackage
`default_nettype wire

@@ design/sfpwe_front.sv @@
// Front end: classifies an incoming byte into line levels and run boundaries.
`default_nettype none
module sfpwe_front (
   input  wire logic              [1:0] mode,
   input  wire sfpwe_pkg::req_type      req,
   output sfpwe_pkg::job_type           job,
   output logic                         has_runs
);

   logic [3:0] last_idx;
   logic [3:0] pulse_cnt;
   sfpwe_pkg::job_type frame_job;
   sfpwe_pkg::job_type pulse_job;

   always_comb begin
      frame_job = '0;
      frame_job.pulse = 1'b0;
      frame_job.levels[0] = 1'b0;
      frame_job.levels[8:1] = req.data_byte;
      if (mode == sfpwe_pkg::MODE_8E2) begin
         frame_job.levels[9]  = ^req.data_byte;
         frame_job.levels[10] = 1'b1;
         frame_job.levels[11] = 1'b1;
         last_idx = 4'd11;
      end else begin
         frame_job.levels[9] = 1'b1;
         last_idx = 4'd9;
      end
      // A run ends where the next level differs, or at the last bit of the frame.
      for (int i = 0; i < sfpwe_pkg::FRAME_MAX_BITS - 1; i++) begin
         if (4'(i) < last_idx) begin
            frame_job.run_ends[i] = frame_job.levels[i] ^ frame_job.levels[i+1];
         end else begin
            frame_job.run_ends[i] = (4'(i) == last_idx);
         end
      end
      frame_job.run_ends[sfpwe_pkg::FRAME_MAX_BITS-1] = (last_idx == 4'd11);
   end

   always_comb begin
      pulse_job = '0;
      pulse_job.pulse = 1'b1;
      pulse_cnt = (req.pulse_bit_count > 4'(sfpwe_pkg::PULSE_MAX_BITS)) ?
                  4'(sfpwe_pkg::PULSE_MAX_BITS) : req.pulse_bit_count;
      // Pulse bits go out most significant first, each one a run of its own.
      for (int i = 0; i < sfpwe_pkg::PULSE_MAX_BITS; i++) begin
         pulse_job.levels[i]   = req.data_byte[sfpwe_pkg::PULSE_MAX_BITS-1-i];
         pulse_job.run_ends[i] = (4'(i) < pulse_cnt);
      end
   end

   always_comb begin
      case (mode)
         sfpwe_pkg::MODE_8N1, sfpwe_pkg::MODE_8E2: begin
            job      = frame_job;
            has_runs = 1'b1;
         end
         sfpwe_pkg::MODE_PULSE: begin
            job      = pulse_job;
            has_runs = (pulse_cnt != 4'd0);
         end
         default: begin
            job      = frame_job;
            has_runs = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ design/sfpwe_queue.sv @@
// Short queue of classified bytes between the front and back ends.
`default_nettype none
module sfpwe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sfpwe_pkg::job_type push_job,
   output logic                    full,
   input  wire logic               pop,
   output logic                    not_empty,
   output sfpwe_pkg::job_type      head_job
);

   localparam int AW = sfpwe_pkg::QUEUE_AW;
   localparam int DEPTH = sfpwe_pkg::QUEUE_DEPTH;

   sfpwe_pkg::job_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff,  count_in;

   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

@@ design/sfpwe_back.sv @@
// Back end: walks the run boundaries of one byte and emits one run per beat.
`default_nettype none
module sfpwe_back #(
   parameter int BIT_TICKS = sfpwe_pkg::BIT_TICKS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               job_ready,
   input  wire sfpwe_pkg::job_type job_head,
   output logic                    job_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sfpwe_pkg::rsp_type      rsp_payload
);

   localparam int NB = sfpwe_pkg::FRAME_MAX_BITS;
   localparam logic [7:0] TICKS = 8'(BIT_TICKS);

   logic               active_ff, active_in;
   sfpwe_pkg::job_type job_ff,    job_in;
   logic [3:0]         start_ff,  start_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sfpwe_pkg::rsp_type rsp_ff,    rsp_in;

   logic [3:0]    end_idx;
   logic [NB-1:0] ends_left;
   logic [3:0]    run_len;
   logic [7:0]    run_prod;
   logic          can_emit;
   logic          fire;
   logic          last;

   always_comb begin
      end_idx = '0;
      for (int i = NB - 1; i >= 0; i--) begin
         if (job_ff.run_ends[i]) begin
            end_idx = 4'(i);
         end
      end
   end

   assign ends_left = job_ff.run_ends & ~(NB'(1) << end_idx);
   assign last      = (ends_left == '0);
   assign run_len   = end_idx - start_ff + 4'd1;
   assign run_prod  = {4'd0, run_len} * TICKS;
   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign fire      = active_ff && can_emit;
   assign job_pop   = job_ready && (!active_ff || (fire && last));

   always_comb begin
      active_in    = active_ff;
      job_in       = job_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (can_emit) begin
         rsp_valid_in = fire;
      end
      if (fire) begin
         if (job_ff.pulse) begin
            rsp_in.run_ticks = job_ff.levels[end_idx] ?
                               sfpwe_pkg::PULSE_ONE_TICKS_M1 :
                               sfpwe_pkg::PULSE_ZERO_TICKS_M1;
         end else begin
            rsp_in.run_ticks = run_prod - 8'd1;
         end
         rsp_in.last_run   = last;
         job_in.run_ends   = ends_left;
         start_in          = end_idx + 4'd1;
         active_in         = !last;
      end
      if (job_pop) begin
         job_in    = job_head;
         start_in  = '0;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      start_ff <= start_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

@@ design/serial_frame_pulse_width_encoder.sv @@
// Top level of the serial frame pulse-width encoder.
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   sfpwe_pkg::req_type
//   rsp       out         rsp_valid/rsp_stall   sfpwe_pkg::rsp_type
//   csr       in          csr_wr_en             csr_wr_data (encoding mode)
//
// A byte is classified in the cycle it is accepted and waits in a two-entry queue.
// The back end emits one run per cycle while rsp is not stalled; a byte has 1 to 10
// runs, and the next byte is loaded as the last run of the current one goes out.
// A byte that yields no runs is dropped at the input. Reset is synchronous.
// A stall on rsp holds the output register; req stalls only when the queue is full.
`default_nettype none
module serial_frame_pulse_width_encoder #(
   parameter int BIT_TICKS = sfpwe_pkg::BIT_TICKS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire sfpwe_pkg::req_type req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sfpwe_pkg::rsp_type      rsp_payload,
   input  wire logic               csr_wr_en,
   input  wire logic         [1:0] csr_wr_data
);

   logic [1:0]         mode_ff, mode_in;
   sfpwe_pkg::job_type front_job;
   sfpwe_pkg::job_type head_job;
   logic               has_runs;
   logic               queue_full;
   logic               queue_not_empty;
   logic               queue_pop;
   logic               queue_push;

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sfpwe_pkg::MODE_8N1;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full && has_runs;

   sfpwe_front u_front (
      .mode     (mode_ff),
      .req      (req_payload),
      .job      (front_job),
      .has_runs (has_runs)
   );

   sfpwe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_job  (front_job),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   sfpwe_back #(
      .BIT_TICKS (BIT_TICKS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_ready   (queue_not_empty),
      .job_head    (head_job),
      .job_pop     (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

@@ tb/sv/tb_serial_frame_pulse_width_encoder.sv @@
// Testbench for the serial frame pulse-width encoder: directed and random bytes checked per beat.
`default_nettype none
module tb_serial_frame_pulse_width_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TICKS_PER_BIT   = 16;
   localparam int ONE_PULSE_M1    = 23;
   localparam int ZERO_PULSE_M1   = 15;
   localparam int MAX_PULSE_BITS  = 8;
   localparam int MAX_GAP         = 12;
   localparam int SETTLE_CYCLES   = 16;
   localparam int LONG_HOLD       = 250;
   localparam int STUCK_LIMIT     = 3000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   sfpwe_pkg::req_type  req_payload;
   logic                rsp_valid;
   logic                rsp_stall;
   sfpwe_pkg::rsp_type  rsp_payload;
   logic                csr_wr_en;
   logic [1:0]          csr_wr_data;

   sfpwe_pkg::rsp_type  run_expect_q[$];
   sfpwe_pkg::mode_type mode_shadow;
   logic                mismatch_seen;
   logic                steady;
   int                  hold_request;
   int                  idle_cycles;

   serial_frame_pulse_width_encoder #(
      .BIT_TICKS(TICKS_PER_BIT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Appends the runs one byte produces under the given mode.
   function automatic void predict_runs(input sfpwe_pkg::mode_type m,
                                        input sfpwe_pkg::req_type r);
      sfpwe_pkg::rsp_type runs[$];
      sfpwe_pkg::rsp_type beat;
      logic [11:0]        levels;
      int                 nlev;
      int                 run_len;
      int                 nb;
      begin
         levels = '0;
         case (m)
            sfpwe_pkg::MODE_PULSE: begin
               nb = (r.pulse_bit_count > MAX_PULSE_BITS) ? MAX_PULSE_BITS :
                    r.pulse_bit_count;
               for (int i = 0; i < nb; i++) begin
                  beat.run_ticks = r.data_byte[7-i] ? 8'(ONE_PULSE_M1) : 8'(ZERO_PULSE_M1);
                  beat.last_run  = (i == nb - 1);
                  runs.push_back(beat);
               end
            end
            sfpwe_pkg::MODE_8N1, sfpwe_pkg::MODE_8E2: begin
               levels[0] = 1'b0;
               for (int i = 0; i < 8; i++) levels[i+1] = r.data_byte[i];
               nlev = 9;
               if (m == sfpwe_pkg::MODE_8E2) begin
                  levels[9]  = ^r.data_byte;
                  levels[10] = 1'b1;
                  nlev = 11;
               end
               levels[nlev] = 1'b1;
               nlev++;
               run_len = 1;
               for (int i = 1; i <= nlev; i++) begin
                  if (i < nlev && levels[i] == levels[i-1]) begin
                     run_len++;
                  end else begin
                     beat.run_ticks = 8'(run_len * TICKS_PER_BIT - 1);
                     beat.last_run  = 1'b0;
                     runs.push_back(beat);
                     run_len = 1;
                  end
               end
               if (runs.size() > 0) runs[runs.size()-1].last_run = 1'b1;
            end
            default: begin
            end
         endcase
         foreach (runs[i]) run_expect_q.push_back(runs[i]);
      end
   endfunction

   // Offers one byte after a random gap and records its runs once it is taken.
   task automatic send_byte(input logic [7:0] data, input logic [3:0] nbits);
      int gap;
      begin
         gap = draw_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid                   <= 1'b1;
         req_payload.data_byte       <= data;
         req_payload.pulse_bit_count <= nbits;
         do @(posedge clock); while (req_stall);
         predict_runs(mode_shadow, '{data_byte: data, pulse_bit_count: nbits});
      end
   endtask

   task automatic quiesce();
      begin
         req_valid <= 1'b0;
         while (run_expect_q.size() != 0) @(posedge clock);
         // A dropped byte leaves nothing to wait for, so give the pipeline time to empty.
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   task automatic set_mode(input sfpwe_pkg::mode_type m);
      begin
         quiesce();
         csr_wr_en   <= 1'b1;
         csr_wr_data <= m;
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         mode_shadow = m;
      end
   endtask

   task automatic send_random(input sfpwe_pkg::mode_type m);
      logic [3:0] nbits;
      begin
         if (m == sfpwe_pkg::MODE_PULSE && $urandom_range(0, 9) < 8) begin
            nbits = 4'($urandom_range(1, MAX_PULSE_BITS));
         end else begin
            nbits = 4'($urandom_range(0, 15));
         end
         send_byte(8'($urandom), nbits);
      end
   endtask

   task automatic test_8n1_frames();
      begin
         set_mode(sfpwe_pkg::MODE_8N1);
         send_byte(8'h00, 4'd0);
         send_byte(8'hFF, 4'd15);
         send_byte(8'h55, 4'd5);
         send_byte(8'hAA, 4'd10);
         send_byte(8'h01, 4'd3);
         send_byte(8'h80, 4'd12);
      end
   endtask

   task automatic test_8e2_frames();
      begin
         set_mode(sfpwe_pkg::MODE_8E2);
         send_byte(8'h00, 4'd8);
         send_byte(8'hFF, 4'd0);
         send_byte(8'h01, 4'd7);
         send_byte(8'h03, 4'd15);
         send_byte(8'h7F, 4'd1);
         send_byte(8'h80, 4'd9);
      end
   endtask

   task automatic test_pulse_coding();
      begin
         set_mode(sfpwe_pkg::MODE_PULSE);
         send_byte(8'hFF, 4'd8);
         send_byte(8'h00, 4'd8);
         send_byte(8'hA5, 4'd1);
         // Counts above eight are clipped, and a zero count sends nothing.
         send_byte(8'h5A, 4'd9);
         send_byte(8'hC3, 4'd15);
         send_byte(8'h81, 4'd0);
         send_byte(8'h3C, 4'd4);
      end
   endtask

   task automatic test_unused_mode();
      begin
         set_mode(sfpwe_pkg::MODE_UNUSED);
         send_byte(8'hFF, 4'd15);
         send_byte(8'h00, 4'd0);
         send_byte(8'h96, 4'd8);
      end
   endtask

   task automatic test_full_queue_stall();
      begin
         set_mode(sfpwe_pkg::MODE_8E2);
         hold_request = LONG_HOLD;
         repeat (12) send_random(sfpwe_pkg::MODE_8E2);
      end
   endtask

   task automatic test_random_traffic();
      sfpwe_pkg::mode_type m;
      begin
         for (int phase = 0; phase < 7; phase++) begin
            case (phase)
               0: m = sfpwe_pkg::MODE_8N1;
               1: m = sfpwe_pkg::MODE_PULSE;
               2: m = sfpwe_pkg::MODE_8E2;
               3: m = sfpwe_pkg::MODE_UNUSED;
               5: m = sfpwe_pkg::MODE_PULSE;
               6: m = sfpwe_pkg::MODE_8N1;
               default: m = sfpwe_pkg::mode_type'($urandom_range(0, 2));
            endcase
            set_mode(m);
            steady = (phase == 2 || phase == 6);
            repeat ((m == sfpwe_pkg::MODE_UNUSED) ? 8 : 24) send_random(m);
            steady = 1'b0;
         end
      end
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      mode_shadow   = sfpwe_pkg::MODE_8N1;
      mismatch_seen = 1'b0;
      steady        = 1'b0;
      hold_request  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_8n1_frames();
      test_8e2_frames();
      test_pulse_coding();
      test_unused_mode();
      test_full_queue_stall();
      test_random_traffic();

      quiesce();
      if (run_expect_q.size() != 0) mismatch_seen = 1'b1;
      if (!mismatch_seen) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Result side: a random hold before each beat, or one long hold when asked for.
   initial begin : result_sink
      int wait_cycles;
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         if (hold_request > 0) begin
            wait_cycles  = hold_request;
            hold_request = 0;
         end else begin
            wait_cycles = draw_gap();
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : check_beat
      sfpwe_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (run_expect_q.size() == 0) begin
            $display("%0t ERROR beat with no run pending: expected none, actual ticks %0d last %0b",
                     $time, rsp_payload.run_ticks, rsp_payload.last_run);
            mismatch_seen = 1'b1;
         end else begin
            want = run_expect_q.pop_front();
            if (rsp_payload.run_ticks !== want.run_ticks) begin
               $display("%0t ERROR run_ticks: expected %0d, actual %0d",
                        $time, want.run_ticks, rsp_payload.run_ticks);
               mismatch_seen = 1'b1;
            end
            if (rsp_payload.last_run !== want.last_run) begin
               $display("%0t ERROR last_run: expected %0b, actual %0b",
                        $time, want.last_run, rsp_payload.last_run);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STUCK_LIMIT) begin
         $display("%0t ERROR no beat moved for %0d cycles", $time, idle_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
`default_nettype wire
